[rtl/gcdl_pkg.sv]
package gcdl_pkg;

    // fixed field widths of the channels
    localparam int FIELD_WIDTH       = 32;
    localparam int ANSWER_WIDTH      = 64;

    // default operand width, may be narrowed by the top level parameter
    localparam int OPERAND_WIDTH_DEF = 32;

    // command codes
    localparam logic CMD_LCM = 1'b0;
    localparam logic CMD_GCD = 1'b1;

endpackage

[rtl/gcd_lcm_unit_core.sv]
// gcd / lcm unit
// input channel: i_in_valid with i_command, i_first_operand, i_second_operand;
// a word is taken when i_in_valid is high and o_in_stall is low. only the low
// OPERAND_WIDTH bits of each operand are used.
// output channel: o_out_valid with o_answer, o_zero_operand; a word leaves when
// o_out_valid is high and i_out_stall is low. one result per input word.
// i_command 1 gives the gcd, 0 the lcm; a zero operand gives gcd = other
// operand, lcm = 0, and raises o_zero_operand.
// one word is worked on at a time; the next word is taken the cycle after the
// result reaches the output register.
// a zero operand goes straight to the finish. the gcd runs binary gcd steps,
// each halving one or both values or subtracting and halving, and then
// restores the shared twos. the lcm follows the gcd with a restoring division
// of the first operand by the gcd and a shift-add multiply of the quotient by
// the second operand, each one bit per cycle. the result waits in an output
// register, so o_in_stall drops once it is loaded even while the receiver
// stalls; a finished word waits inside only when the output register is still
// full.
// reset (synchronous, active low) drops all valids and returns to idle.
module gcd_lcm_unit_core #(
    parameter int OPERAND_WIDTH = gcdl_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic [gcdl_pkg::FIELD_WIDTH-1:0]  i_first_operand,
    input  logic [gcdl_pkg::FIELD_WIDTH-1:0]  i_second_operand,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [gcdl_pkg::ANSWER_WIDTH-1:0] o_answer,
    output logic                              o_zero_operand
);
    import gcdl_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GCD  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic              r_cmd, n_cmd;
    logic              r_zero, n_zero;
    logic [W-1:0]      r_x, n_x;
    logic [W-1:0]      r_y, n_y;
    logic [W-1:0]      r_g, n_g;
    logic [W-1:0]      r_rem, n_rem;
    logic [W-1:0]      r_quo, n_quo;
    logic [2*W-1:0]    r_res, n_res;
    logic [CW-1:0]     r_cnt, n_cnt;

    logic              r_out_vld, n_out_vld;
    logic [ANSWER_WIDTH-1:0] r_answer, n_answer;
    logic              r_zero_out, n_zero_out;

    logic              in_take;
    logic              out_take;
    logic              out_free;
    logic [W-1:0]      in_x;
    logic [W-1:0]      in_y;
    logic              in_zero;
    logic              gcd_start;
    logic              gcd_done;
    logic [W-1:0]      gcd_val;
    logic [W:0]        rem_sh;
    logic [W:0]        rem_diff;
    logic              last_bit;

    assign in_take  = i_in_valid && (r_state == ST_IDLE);
    assign out_take = r_out_vld && !i_out_stall;
    assign out_free = !r_out_vld || !i_out_stall;
    assign in_x     = i_first_operand[W-1:0];
    assign in_y     = i_second_operand[W-1:0];
    assign in_zero  = (in_x == '0) || (in_y == '0);

    assign gcd_start = in_take && !in_zero;

    gcdl_bgcd #(
        .OPERAND_WIDTH (W)
    ) u_bgcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_a     (in_x),
        .i_b     (in_y),
        .o_done  (gcd_done),
        .o_gcd   (gcd_val)
    );

    // restoring division step, one quotient bit per cycle
    assign rem_sh   = {r_rem, r_quo[W-1]};
    assign rem_diff = rem_sh - {1'b0, r_g};
    assign last_bit = (r_cnt == CW'(W - 1));

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_zero     = r_zero;
        n_x        = r_x;
        n_y        = r_y;
        n_g        = r_g;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_res      = r_res;
        n_cnt      = r_cnt;
        n_out_vld  = out_take ? 1'b0 : r_out_vld;
        n_answer   = r_answer;
        n_zero_out = r_zero_out;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_cmd  = i_command;
                    n_zero = in_zero;
                    n_x    = in_x;
                    n_y    = in_y;
                    if (in_zero) begin
                        n_res   = (i_command == CMD_GCD) ? (2*W)'(in_x | in_y) : '0;
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_GCD;
                    end
                end
            end
            ST_GCD: begin
                if (gcd_done) begin
                    n_g = gcd_val;
                    if (r_cmd == CMD_GCD) begin
                        n_res   = (2*W)'(gcd_val);
                        n_state = ST_FIN;
                    end else begin
                        n_rem   = '0;
                        n_quo   = r_x;
                        n_cnt   = '0;
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_rem = rem_diff[W] ? rem_sh[W-1:0] : rem_diff[W-1:0];
                n_quo = {r_quo[W-2:0], !rem_diff[W]};
                n_cnt = r_cnt + CW'(1);
                if (last_bit) begin
                    n_cnt   = '0;
                    n_res   = '0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                // quotient msb first, accumulate quotient times second operand
                n_res = {r_res[2*W-2:0], 1'b0} + (r_quo[W-1] ? (2*W)'(r_y) : '0);
                n_quo = r_quo << 1;
                n_cnt = r_cnt + CW'(1);
                if (last_bit) begin
                    n_cnt   = '0;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_answer   = ANSWER_WIDTH'(r_res);
                    n_zero_out = r_zero;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
        r_cmd      <= n_cmd;
        r_zero     <= n_zero;
        r_x        <= n_x;
        r_y        <= n_y;
        r_g        <= n_g;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_res      <= n_res;
        r_cnt      <= n_cnt;
        r_answer   <= n_answer;
        r_zero_out <= n_zero_out;
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_answer       = r_answer;
    assign o_zero_operand = r_zero_out;

`ifndef ASSERT_OFF
    // engine finishes only while the control waits on it
    a_done_in_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gcd_done |-> (r_state == ST_GCD))
        else $error("gcd done outside gcd wait");

    // remainder stays below the divisor through the division
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_g))
        else $error("division remainder not below divisor");

    // a zero operand lcm always leaves as zero
    a_zero_lcm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FIN) && r_zero && (r_cmd == CMD_LCM)) |-> (r_res == '0))
        else $error("lcm with zero operand not zero");

    // an accepted word leaves the idle state at once
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state != ST_IDLE))
        else $error("accepted word did not start");
`endif

endmodule

[rtl/gcdl_bgcd.sv]
module gcdl_bgcd #(
    parameter int OPERAND_WIDTH = gcdl_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [OPERAND_WIDTH-1:0] i_a,
    input  logic [OPERAND_WIDTH-1:0] i_b,
    output logic                     o_done,
    output logic [OPERAND_WIDTH-1:0] o_gcd
);
    import gcdl_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int KW = $clog2(W);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [W-1:0]  r_a, n_a;
    logic [W-1:0]  r_b, n_b;
    logic [KW-1:0] r_k, n_k;

    logic [W:0]    diff_ab;
    logic [W-1:0]  diff_ba;

    assign diff_ab = {1'b0, r_a} - {1'b0, r_b};
    assign diff_ba = r_b - r_a;

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_k     = r_k;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_a     = i_a;
                    n_b     = i_b;
                    n_k     = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_a == r_b) begin
                    n_state = ST_SHIFT;
                end else if (!r_a[0] && !r_b[0]) begin
                    // shared factor of two, restored at the end
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + KW'(1);
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (!diff_ab[W]) begin
                    n_a = {1'b0, diff_ab[W-1:1]};
                end else begin
                    n_b = {1'b0, diff_ba[W-1:1]};
                end
            end
            ST_SHIFT: begin
                if (r_k == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_a = r_a << 1;
                    n_k = r_k - KW'(1);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_k <= n_k;
    end

    assign o_done = (r_state == ST_SHIFT) && (r_k == '0);
    assign o_gcd  = r_a;

`ifndef ASSERT_OFF
    // both values stay nonzero through the reduction
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_a != '0) && (r_b != '0))
        else $error("gcd engine operand reached zero");

    // a start is only given while the engine is free
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == ST_IDLE))
        else $error("gcd engine started while busy");
`endif

endmodule
